[rtl/rta_pkg.sv]
// Shared types and constants for the response-time analysis block.
`timescale 1ns / 1ps

package rta_pkg;

  // Default sizing
  localparam int unsigned MAX_TASKS_DEF = 32;
  localparam int unsigned TIME_BITS_DEF = 24;

  // Fixed field widths
  localparam int unsigned TASK_W  = 16;
  localparam int unsigned LIMIT_W = 24;
  localparam int unsigned RESP_W  = 24;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

  // Result status codes
  localparam logic STATUS_CONVERGED = 1'b0;
  localparam logic STATUS_OVERFLOW  = 1'b1;

  // Input transaction
  typedef struct packed {
    logic [TASK_W-1:0] task_period;
    logic [TASK_W-1:0] task_wcet;
    logic              last_task;
  } rta_in_t;

  // Result transaction
  typedef struct packed {
    logic [RESP_W-1:0] response_time;
    logic              status;
  } rta_out_t;

  // One stored higher-priority task
  typedef struct packed {
    logic [TASK_W-1:0] period;
    logic [TASK_W-1:0] wcet;
  } rta_task_t;

endpackage

[rtl/rta_task_mem.sv]
// Task table memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module rta_task_mem import rta_pkg::*; #(
  parameter int unsigned DEPTH = MAX_TASKS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rta_task_t     wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output rta_task_t     rd_data
);

  rta_task_t mem_r [DEPTH];
  rta_task_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/rta_ceil_div.sv]
// Bit-serial restoring divider returning ceil(dividend / divisor).
`timescale 1ns / 1ps

module rta_ceil_div import rta_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] dividend,
  input  logic [TASK_W-1:0]    divisor,
  output logic                 done,
  output logic [TIME_BITS-1:0] quot
);

  localparam int unsigned CNTW = $clog2(TIME_BITS + 1);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIN
  } div_state_t;

  div_state_t           state_r;
  logic [CNTW-1:0]      cnt_r;
  logic [TIME_BITS-1:0] dq_r;     // dividend shifts out, quotient shifts in
  logic [TASK_W-1:0]    rem_r;
  logic [TASK_W-1:0]    dvs_r;
  logic [TIME_BITS-1:0] quot_r;
  logic                 done_r;

  logic [TASK_W:0]      shifted;
  logic [TASK_W:0]      diff;
  logic                 ge;
  logic [TASK_W-1:0]    rem_nxt;
  logic [TIME_BITS-1:0] quot_nxt;

  // One quotient bit per cycle
  always_comb begin
    shifted  = {rem_r, dq_r[TIME_BITS-1]};
    diff     = shifted - {1'b0, dvs_r};
    ge       = (shifted >= {1'b0, dvs_r});
    rem_nxt  = ge ? diff[TASK_W-1:0] : shifted[TASK_W-1:0];
    // round up on a nonzero remainder
    quot_nxt = dq_r + TIME_BITS'(rem_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      // done pulses for one cycle after the final step
      done_r <= (state_r == D_FIN);
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            dq_r    <= dividend;
            rem_r   <= '0;
            // zero period counts as one
            dvs_r   <= (divisor == '0) ? TASK_W'(1) : divisor;
            cnt_r   <= CNTW'(TIME_BITS);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          dq_r  <= {dq_r[TIME_BITS-2:0], ge};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - CNTW'(1);
          if (cnt_r == CNTW'(1)) begin
            state_r <= D_FIN;
          end
        end
        D_FIN: begin
          quot_r  <= quot_nxt;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[rtl/rta_core.sv]
// Task loader and fixed-point sequencer over the task table memory.
`timescale 1ns / 1ps

module rta_core import rta_pkg::*; #(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  rta_in_t            item,
  input  logic [LIMIT_W-1:0] limit,
  input  logic               res_ready,
  output logic               busy,
  output logic               res_valid,
  output rta_out_t           res
);

  localparam int unsigned CW   = $clog2(MAX_TASKS + 1);
  localparam int unsigned AW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned LW   = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;
  localparam int unsigned ACCW = TIME_BITS + 1;   // top bit marks saturation
  localparam int unsigned PW   = TIME_BITS + TASK_W;

  localparam logic [ACCW-1:0] SAT_VAL = {1'b1, {TIME_BITS{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_CHECK,
    S_FETCH,
    S_DIVGO,
    S_DIV,
    S_ACC,
    S_CMP,
    S_DONE
  } core_state_t;

  core_state_t          state_r;
  logic                 expect_target_r;
  logic [CW-1:0]        hp_count_r;
  rta_task_t            target_r;
  logic [CW-1:0]        term_r;
  logic [ACCW-1:0]      len_r;
  logic [ACCW-1:0]      acc_r;
  logic [TASK_W-1:0]    wcet_r;
  logic [PW-1:0]        prod_r;
  rta_out_t             res_r;

  logic                 wr_en;
  rta_task_t            wr_data;
  logic                 rd_en;
  logic [CW-1:0]        term_m1;
  rta_task_t            rd_data;

  logic                 div_start;
  logic [TASK_W-1:0]    div_divisor;
  logic                 div_done;
  logic [TIME_BITS-1:0] div_quot;

  logic [LW-1:0]        lim_ext;
  logic [LW-1:0]        tmax_ext;
  logic [LW-1:0]        lim_sel;
  logic [TIME_BITS-1:0] lim_clamp;
  logic                 len_over;
  logic [ACCW-1:0]      prod_sat;
  logic [ACCW:0]        sum;
  logic [ACCW-1:0]      acc_nxt;
  logic [TIME_BITS-1:0] len_clip;
  logic [RESP_W-1:0]    resp;

  // Table writes during loading, reads one entry ahead of the divider
  assign wr_en   = (state_r == S_IDLE) && item_valid && !expect_target_r &&
                   (hp_count_r < CW'(MAX_TASKS));
  assign wr_data = '{period: item.task_period, wcet: item.task_wcet};
  assign term_m1 = term_r - CW'(1);
  assign rd_en   = (state_r == S_FETCH) && (term_r != '0);

  rta_task_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (hp_count_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (term_m1[AW-1:0]),
    .rd_data (rd_data)
  );

  // Term zero is the analysed task itself
  assign div_start   = (state_r == S_DIVGO);
  assign div_divisor = (term_r == '0) ? target_r.period : rd_data.period;

  rta_ceil_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (len_r[TIME_BITS-1:0]),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Limit clamp, saturating accumulate, result formatting
  always_comb begin
    lim_ext   = LW'(limit);
    tmax_ext  = LW'({TIME_BITS{1'b1}});
    lim_sel   = (lim_ext > tmax_ext) ? tmax_ext : lim_ext;
    lim_clamp = lim_sel[TIME_BITS-1:0];
    len_over  = (len_r > ACCW'(lim_clamp));
    prod_sat  = (prod_r[PW-1:TIME_BITS] != '0) ? SAT_VAL : ACCW'(prod_r[TIME_BITS-1:0]);
    sum       = {1'b0, acc_r} + {1'b0, prod_sat};
    acc_nxt   = (sum > (ACCW+1)'(SAT_VAL)) ? SAT_VAL : sum[ACCW-1:0];
    len_clip  = len_r[TIME_BITS] ? {TIME_BITS{1'b1}} : len_r[TIME_BITS-1:0];
    resp      = RESP_W'(len_clip);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      expect_target_r <= 1'b1;
      hp_count_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (item_valid) begin
            if (expect_target_r) begin
              target_r   <= '{period: item.task_period, wcet: item.task_wcet};
              hp_count_r <= '0;
            end else if (hp_count_r < CW'(MAX_TASKS)) begin
              hp_count_r <= hp_count_r + CW'(1);
            end
            // the final task of a set makes the next one an analysed task
            expect_target_r <= item.last_task;
            if (item.last_task) begin
              state_r <= S_START;
            end
          end
        end
        S_START: begin
          len_r   <= ACCW'(target_r.wcet);
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (len_over) begin
            res_r   <= '{response_time: resp, status: STATUS_OVERFLOW};
            state_r <= S_DONE;
          end else begin
            acc_r   <= '0;
            term_r  <= '0;
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          state_r <= S_DIVGO;
        end
        S_DIVGO: begin
          wcet_r  <= (term_r == '0) ? target_r.wcet : rd_data.wcet;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            prod_r  <= div_quot * wcet_r;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          acc_r  <= acc_nxt;
          term_r <= term_r + CW'(1);
          if (term_r == hp_count_r) begin
            state_r <= S_CMP;
          end else begin
            state_r <= S_FETCH;
          end
        end
        S_CMP: begin
          if (acc_r == len_r) begin
            res_r   <= '{response_time: resp, status: STATUS_CONVERGED};
            state_r <= S_DONE;
          end else begin
            len_r   <= acc_r;
            state_r <= S_CHECK;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

[rtl/response_time_analysis.sv]
// Top level: channels, limit register and result register around the core.
//
//   channel   direction  handshake           transaction
//   in_       input      in_valid/in_stall   rta_in_t  (one task)
//   out_      output     out_valid/out_stall rta_out_t (response time, status)
//   cfg_      input      cfg_valid/cfg_ready response_limit, 24 bits
//
// Tasks load at one per cycle; higher-priority ones go into the task table. The item
// marking the end of a set starts the fixed point; each iteration runs the bit-serial
// divider over the H+1 task terms for H higher-priority tasks, one task term at a time.
// Input is stalled from the final item until the result moves to the output register.
// Synchronous reset clears control state and the limit register (all ones). A stalled
// result holds in the output register while the next set loads.
`timescale 1ns / 1ps

module response_time_analysis import rta_pkg::*; #(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rta_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rta_out_t           out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  logic [LIMIT_W-1:0] limit_r;
  logic               out_valid_r;
  rta_out_t           out_data_r;
  logic               out_free;
  logic               core_busy;
  logic               core_res_valid;
  rta_out_t           core_res;

  // Limit register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  rta_core #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid && !in_stall),
    .item       (in_data),
    .limit      (limit_r),
    .res_ready  (out_free),
    .busy       (core_busy),
    .res_valid  (core_res_valid),
    .res        (core_res)
  );

  assign in_stall = core_busy;

  // Output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_res_valid && out_free) begin
      out_valid_r <= 1'b1;
      out_data_r  <= core_res;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/rta_checker.sv]
// Port-level checks for the response-time analysis block, bound to the top.
`timescale 1ns / 1ps

module rta_checker import rta_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input rta_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input rta_out_t out_data
);

  // Reset leaves no result and an open input
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Loading a non-final task never blocks the next one
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.last_task |=> !in_stall)
    else $error("input stalled during task loading");

  // The final task starts analysis, which stalls input
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_task |=> in_stall)
    else $error("analysis did not stall input");

  // A new result only comes out of a running analysis
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without analysis");

endmodule

bind response_time_analysis rta_checker u_rta_checker (.*);

[dv/response_time_checker.sv]
// Checker for response_time_analysis: predicts each response time and compares results.
`timescale 1ns / 1ps

module response_time_checker import rta_pkg::*; #(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rta_in_t            in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rta_out_t           out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  output int unsigned        fail_count,
  output int unsigned        open_results
);

  localparam int unsigned REPORT_MAX = 10;

  // Shadow of the loaded task set and the limit register
  rta_task_t          target_task;
  rta_task_t          hp_tasks [MAX_TASKS];
  int unsigned        hp_loaded;
  bit                 want_target;
  logic [LIMIT_W-1:0] limit_shadow;

  rta_out_t predicted_results [$];

  // Demand of one task over a window: ceil(len/period) * wcet, period 0 taken as 1
  function automatic longint unsigned task_demand(input longint unsigned len,
                                                  input rta_task_t t);
    longint unsigned p;
    p = (t.period == '0) ? 64'd1 : 64'(t.period);
    return ((len + p - 1) / p) * 64'(t.wcet);
  endfunction

  // Fixed point of the response-time recurrence for the loaded set
  function automatic rta_out_t solve_response();
    longint unsigned span_max, lim, len, acc;
    bit              done;
    rta_out_t        r;
    span_max = (64'd1 << TIME_BITS) - 1;
    lim      = 64'(limit_shadow);
    if (lim > span_max) lim = span_max;
    len      = 64'(target_task.wcet);
    r.status = STATUS_CONVERGED;
    done     = 1'b0;
    while (!done) begin
      if (len > lim) begin
        r.status = STATUS_OVERFLOW;
        done     = 1'b1;
      end else begin
        acc = task_demand(len, target_task);
        for (int k = 0; k < hp_loaded; k++) acc += task_demand(len, hp_tasks[k]);
        if (acc == len) done = 1'b1;
        else len = acc;
      end
    end
    if (len > span_max) len = span_max;
    r.response_time = len[RESP_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    rta_out_t want;
    if (!rst_n) begin
      hp_loaded    = 0;
      want_target  = 1'b1;
      target_task  = '0;
      limit_shadow = LIMIT_RESET;
      fail_count   = 0;
      open_results = 0;
    end else begin
      // Limit register write
      if (cfg_valid && cfg_ready) limit_shadow = cfg_data;

      // Task transaction: load, and solve on the final task of a set
      if (in_valid && !in_stall) begin
        if (want_target) begin
          target_task.period = in_data.task_period;
          target_task.wcet   = in_data.task_wcet;
          hp_loaded          = 0;
          want_target        = 1'b0;
        end else if (hp_loaded < MAX_TASKS) begin
          hp_tasks[hp_loaded].period = in_data.task_period;
          hp_tasks[hp_loaded].wcet   = in_data.task_wcet;
          hp_loaded++;
        end
        if (in_data.last_task) begin
          predicted_results = {predicted_results, solve_response()};
          want_target = 1'b1;
        end
      end

      // Result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("%0t: result with nothing predicted: response_time %0d status %0d",
                     $realtime, out_data.response_time, out_data.status);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          if (out_data.response_time !== want.response_time ||
              out_data.status !== want.status) begin
            if (fail_count < REPORT_MAX)
              $display("%0t: mismatch: response_time exp %0d got %0d, status exp %0d got %0d",
                       $realtime, want.response_time, out_data.response_time,
                       want.status, out_data.status);
            fail_count++;
          end
        end
      end
      open_results = predicted_results.size();
    end
  end

endmodule

[dv/response_time_analysis_test.sv]
// Testbench top for response_time_analysis: clock, reset, task-set stimulus and verdict.
`timescale 1ns / 1ps

module response_time_analysis_test;
  import rta_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned PHASE_SETS   = 40;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned CYCLE_LIMIT  = 10_000_000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  rta_in_t            in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rta_out_t           out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data  = '0;

  int unsigned check_failures;
  int unsigned check_open;
  int unsigned items_sent   = 0;
  int unsigned sets_sent    = 0;
  int unsigned results_seen = 0;
  int unsigned cycles       = 0;
  bit          jitter_on    = 1'b1;
  bit          hold_req     = 1'b0;
  logic        hold_off     = 1'b0;

  response_time_analysis dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  response_time_checker rt_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (check_failures),
    .open_results (check_open)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off
  always @(posedge clk) begin
    out_stall <= hold_off || (jitter_on && $urandom_range(99) < 10);
  end

  // Long receiver hold-off, counted here while the sender keeps going
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Count result transactions
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) results_seen <= results_seen + 1;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One task transaction, with an occasional gap ahead of it
  task automatic push_task(input int unsigned period, input int unsigned wcet,
                           input bit last);
    rta_in_t item;
    item.task_period = period[TASK_W-1:0];
    item.task_wcet   = wcet[TASK_W-1:0];
    item.last_task   = last;
    if (jitter_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (last) sets_sent++;
  endtask

  // Drop valid and wait for every pending result, then a quiet tail
  task automatic wait_idle(input int unsigned tail);
    in_valid <= 1'b0;
    while (results_seen != sets_sent) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Low utilization (<= 1/4), wcets within 2x of each other: converges in few steps
  task automatic send_light_set();
    int unsigned hp, base, c, lo, hi;
    hp   = $urandom_range(0, 7);
    base = $urandom_range(1, 65535 / (8 * (hp + 1)));
    for (int k = 0; k <= hp; k++) begin
      c  = $urandom_range(base, 2 * base);
      lo = 4 * (hp + 1) * c;
      hi = 16 * (hp + 1) * c;
      if (hi > 65535) hi = 65535;
      if (k == 0 && $urandom_range(19) == 0) c = 0;
      push_task($urandom_range(lo, hi), c, k == hp);
    end
  endtask

  // Analysed task with wcet >= 2*period: demand at least doubles, so it overflows quickly
  task automatic send_heavy_set();
    int unsigned hp, c;
    hp = $urandom_range(0, 7);
    c  = $urandom_range(2, 65535);
    push_task($urandom_range(1, c / 2), c, hp == 0);
    for (int k = 1; k <= hp; k++)
      push_task(($urandom_range(7) == 0) ? 0 : $urandom_range(1, 65535),
                $urandom_range(0, 65535), k == hp);
  endtask

  // Analysed task alone
  task automatic send_single_set();
    int unsigned p, c;
    if ($urandom_range(1)) begin
      p = $urandom_range(0, 65535);
      c = $urandom_range(0, p);
    end else begin
      p = $urandom_range(0, 32767);
      c = $urandom_range(2 * p, 65535);
    end
    push_task(p, c, 1'b1);
  endtask

  // More higher-priority tasks than the table holds; the extras must be dropped
  task automatic send_long_set();
    int unsigned hp;
    hp = $urandom_range(MAX_TASKS_DEF + 1, MAX_TASKS_DEF + 4);
    push_task($urandom_range(1000, 65535), $urandom_range(1, 4), 1'b0);
    for (int k = 1; k <= hp; k++) begin
      if (k <= MAX_TASKS_DEF) push_task($urandom_range(256, 65535), 1, k == hp);
      else push_task($urandom_range(0, 65535), $urandom_range(0, 65535), k == hp);
    end
  endtask

  initial begin : stimulus
    int unsigned phase, random_items, phase_sets, start_count, pick;
    logic [LIMIT_W-1:0] lim;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, limit at its reset value
    push_task(65535, 65535, 1'b1);      // full-range single task
    push_task(0, 0, 1'b1);              // zero period, zero wcet
    push_task(10, 0, 1'b0);             // zero wcet for the analysed task
    push_task(20, 3, 1'b0);
    push_task(7, 1, 1'b1);
    push_task(12, 3, 1'b0);             // textbook three-task set
    push_task(4, 1, 1'b0);
    push_task(6, 2, 1'b1);
    push_task(1000, 1, 1'b0);           // zero period hp: runs past the time range
    push_task(0, 2, 1'b1);
    push_task(1, 65535, 1'b1);          // first step overshoots, saturates
    send_long_set();

    // Smallest limit
    wait_idle(4);
    write_limit(LIMIT_W'(1));
    push_task(9, 1, 1'b1);
    push_task(9, 2, 1'b1);              // wcet already above the limit
    push_task(50, 1, 1'b0);
    push_task(50, 1, 1'b1);

    // Mid limit
    wait_idle(4);
    write_limit(LIMIT_W'(1000));
    push_task(3000, 2000, 1'b1);
    push_task(40, 10, 1'b0);
    push_task(0, 0, 1'b1);

    // Random phases, each under its own limit
    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle(4);
      if (phase == 0) lim = LIMIT_RESET;
      else begin
        case ($urandom_range(0, 3))
          0:       lim = LIMIT_W'(1);
          1:       lim = LIMIT_W'($urandom_range(1, 5000));
          2:       lim = LIMIT_W'($urandom_range(1, 24'hFF_FFFF));
          default: lim = LIMIT_RESET;
        endcase
      end
      write_limit(lim);
      jitter_on  = (phase != 2);
      phase_sets = 0;
      while (phase_sets < PHASE_SETS && random_items < RANDOM_ITEMS) begin
        start_count = items_sent;
        if (phase == 1 && phase_sets == 5) hold_req = 1'b1;
        pick = $urandom_range(99);
        if (pick < 50) send_light_set();
        else if (pick < 80) send_heavy_set();
        else if (pick < 97) send_single_set();
        else send_long_set();
        random_items += items_sent - start_count;
        phase_sets++;
      end
      phase++;
    end

    wait_idle(50);
    if (check_failures == 0 && check_open == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
